>>> design/pps_pkg.sv
package pps_pkg;

    // One input word: a slot load or a scheduling tick.
    typedef struct packed {
        logic        kind;
        logic [2:0]  slot;
        logic [15:0] arrives_at;
        logic [15:0] run_length;
        logic [7:0]  urgency_rank;
    } t_item;

    // One result word, one per accepted input word.
    typedef struct packed {
        logic        ran_valid;
        logic [2:0]  ran_slot;
        logic        finished;
        logic [31:0] wait_ticks;
        logic [31:0] turn_ticks;
        logic [31:0] now_tick;
        logic        all_done;
    } t_result;

    // Per-slot record held in the slot memory.
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] length;
        logic [7:0]  rank;
        logic [15:0] remaining;
    } t_entry;

    // Candidate presented to the selector on each scan cycle.
    typedef struct packed {
        logic   elig;
        t_entry entry;
    } t_cand;

    // Running best of the scan.
    typedef struct packed {
        logic   found;
        t_entry entry;
    } t_best;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

endpackage

>>> design/pps_ram.sv
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> design/pps_pick.sv
module pps_pick #(
    parameter int SLOT_W = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  pps_pkg::t_cand      i_cand,
    input  logic [SLOT_W-1:0]   i_slot,
    output pps_pkg::t_best      o_best,
    output logic [SLOT_W-1:0]   o_best_slot
);

    import pps_pkg::*;

    t_best             r_best;
    logic [SLOT_W-1:0] r_slot;
    logic              take;

    // Strict compares keep the earlier slot on a full tie.
    always_comb begin
        take = i_cand.elig &&
               (!r_best.found ||
                (i_cand.entry.rank < r_best.entry.rank) ||
                ((i_cand.entry.rank == r_best.entry.rank) &&
                 (i_cand.entry.arrival < r_best.entry.arrival)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_best.found <= 1'b0;
        end else if (take) begin
            r_best.found <= 1'b1;
        end
        if (take && !i_clear) begin
            r_best.entry <= i_cand.entry;
            r_slot       <= i_slot;
        end
    end

    assign o_best      = r_best;
    assign o_best_slot = r_slot;

endmodule

>>> design/preemptive_priority_scheduler_core.sv
// Preemptive priority scheduler over a small table of task slots.
// Input: a word on i_item is taken at a clock edge where start is high and
// busy is low. A load word writes one slot (arrival, run length, rank) and
// restarts it; a load to a slot at or above NUM_SLOTS changes nothing. A tick
// word serves one tick to the ready, unfinished task of lowest rank (ties to
// earlier arrival, then lower slot) and advances the saturating tick count.
// Output: every input word gives exactly one result word on o_result, shown
// for one cycle with o_valid high. The receiver cannot stall this channel,
// and none is needed: a result is presented once and then dropped.
// A load word goes from the accepting edge through the response state to
// the result register. A tick word goes through a scan read of every slot,
// the last compare in the selector, the write-back, the result register
// and the cycle the result is shown. The tick time is set by the slot memory's
// single read port: the scan reads one slot per cycle into one comparator.
// busy stays high until the result is registered, so one word is in flight and
// the next word can be taken at the edge that takes the result.
// Reset clears the tick count and all loaded and finished marks; slot
// contents are undefined until loaded and are only used for loaded slots.
module preemptive_priority_scheduler_core #(
    parameter int NUM_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  pps_pkg::t_item    i_item,
    output logic              busy,
    output logic              o_valid,
    output pps_pkg::t_result  o_result
);

    import pps_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPD,
        S_RESP
    } t_state;

    t_state                r_state;
    logic [31:0]           r_tick;
    logic [NUM_SLOTS-1:0]  r_loaded;
    logic [NUM_SLOTS-1:0]  r_done;
    logic [SW-1:0]         r_addr;
    logic                  r_cand_vld;
    logic [SW-1:0]         r_cand_slot;
    logic                  r_valid;
    t_result               r_out;

    logic                  accept;
    logic                  load_ok;
    logic [SW-1:0]         load_idx;
    logic                  mem_we;
    logic [SW-1:0]         mem_waddr;
    t_entry                mem_wdata;
    t_entry                mem_rdata;
    t_cand                 cand;
    logic                  clear_pick;
    t_best                 best;
    logic [SW-1:0]         best_slot;
    logic [31:0]           n_tick;
    logic [31:0]           turn;
    logic [31:0]           wait_t;

    assign accept   = start && (r_state == S_IDLE);
    assign load_ok  = (32'(i_item.slot) < NUM_SLOTS);
    assign load_idx = SW'(i_item.slot);
    assign clear_pick = accept && (i_item.kind == KIND_TICK);

    // A slot is ready once its arrival is at or before the current tick.
    always_comb begin
        cand.entry = mem_rdata;
        cand.elig  = r_cand_vld && r_loaded[r_cand_slot] && !r_done[r_cand_slot] &&
                     ((r_tick[31:16] != 16'd0) || (mem_rdata.arrival <= r_tick[15:0]));
    end

    // The write-back happens after the scan has finished reading, and busy
    // holds off the next word, so no write lands on a slot whose read data is still used.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = load_idx;
        mem_wdata.arrival   = i_item.arrives_at;
        mem_wdata.length    = i_item.run_length;
        mem_wdata.rank      = i_item.urgency_rank;
        mem_wdata.remaining = i_item.run_length;
        if (r_state == S_UPD) begin
            mem_we    = best.found;
            mem_waddr = best_slot;
            mem_wdata = best.entry;
            mem_wdata.remaining = best.entry.remaining - 16'd1;
        end else if (accept && (i_item.kind == KIND_LOAD) && load_ok) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        n_tick = (r_tick == 32'hFFFF_FFFF) ? r_tick : r_tick + 32'd1;
        turn   = n_tick - 32'(best.entry.arrival);
        wait_t = (turn >= 32'(best.entry.length)) ? turn - 32'(best.entry.length) : 32'd0;
    end

    pps_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    pps_pick #(
        .SLOT_W (SW)
    ) u_pick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (clear_pick),
        .i_cand      (cand),
        .i_slot      (r_cand_slot),
        .o_best      (best),
        .o_best_slot (best_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tick     <= 32'd0;
            r_loaded   <= '0;
            r_done     <= '0;
            r_addr     <= '0;
            r_cand_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid     <= 1'b0;
            r_cand_vld  <= 1'b0;
            r_cand_slot <= r_addr;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_out.ran_valid  <= 1'b0;
                        r_out.ran_slot   <= 3'd0;
                        r_out.finished   <= 1'b0;
                        r_out.wait_ticks <= 32'd0;
                        r_out.turn_ticks <= 32'd0;
                        r_out.now_tick   <= r_tick;
                        r_addr           <= '0;
                        if (i_item.kind == KIND_LOAD) begin
                            if (load_ok) begin
                                r_loaded[load_idx] <= 1'b1;
                                r_done[load_idx]   <= (i_item.run_length == 16'd0);
                            end
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_cand_vld <= 1'b1;
                    if (r_addr == LAST_SLOT) begin
                        r_state <= S_LAST;
                    end else begin
                        r_addr <= r_addr + SW'(1);
                    end
                end
                S_LAST: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_tick         <= n_tick;
                    r_out.now_tick <= n_tick;
                    if (best.found) begin
                        r_out.ran_valid <= 1'b1;
                        r_out.ran_slot  <= 3'(best_slot);
                        if (best.entry.remaining == 16'd1) begin
                            r_done[best_slot] <= 1'b1;
                            r_out.finished    <= 1'b1;
                            r_out.wait_ticks  <= wait_t;
                            r_out.turn_ticks  <= turn;
                        end
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    r_out.all_done <= ~|(r_loaded & ~r_done);
                    r_valid        <= 1'b1;
                    r_state        <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule
